// ===== design/oas_pkg.sv =====
// Shared types and constants for the olympic average ADC smoother.
// Used by oas_ctrl, oas_dp and the top level; no dependencies.
package oas_pkg;

	localparam int RING_LEN   = 10;     // history entries per channel
	localparam int SAMPLE_W   = 12;
	localparam int SCALE_W    = 16;
	localparam int FRAC_W     = 16;     // Q16 scale factor
	localparam int SUM_W      = 16;     // holds ten 12-bit entries
	localparam int POS_W      = 4;      // ring position 0..9
	localparam int IDX_W      = 4;      // scan index 0..RING_LEN
	localparam int CHAN_OUT_W = 3;
	localparam int PROD_W     = SAMPLE_W + SCALE_W;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = '1;
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd52800;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_AVG,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_sample;  // capture the incoming request
		logic write_hist;   // update raw value, ring entry and fill position
		logic scan;         // step the history scan
		logic calc_avg;     // trimmed mean and new smoothed value
		logic calc_mul;     // scale multiply
		logic emit;         // load the output register
		logic advance;      // move to the next channel
	} ctrl_cmd_t;

	typedef struct packed {
		logic wrap;         // current write lands on the last ring slot
		logic scan_done;    // all ring entries accumulated
		logic out_free;     // output register can take a result
	} dp_sts_t;

endpackage

// ===== design/oas_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module oas_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/oas_ctrl.sv =====
// Sequencing state machine for the olympic average ADC smoother.
// Depends on oas_pkg; drives oas_dp through ctrl_cmd_t / dp_sts_t.
module oas_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  oas_pkg::dp_sts_t   sts,
	output oas_pkg::ctrl_cmd_t cmd
);
	import oas_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.load_sample = 1'b1;
					state_nxt       = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_hist = 1'b1;
				if (sts.wrap) begin
					state_nxt = ST_SCAN;
				end else begin
					cmd.advance = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.calc_avg = 1'b1;
				state_nxt    = ST_MUL;
			end
			ST_MUL: begin
				cmd.calc_mul = 1'b1;
				state_nxt    = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.advance = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/oas_dp.sv =====
// Datapath: per-channel running values, history ring in RAM, trimmed-sum
// scan, smoothing, scale multiply and output register. Depends on oas_pkg, oas_ram.
module oas_dp #(
	parameter int CHANNELS  = 8,
	parameter int AVG_SHIFT = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  oas_pkg::ctrl_cmd_t                   cmd,
	output oas_pkg::dp_sts_t                     sts,
	input  logic [oas_pkg::SAMPLE_W-1:0]         raw_sample,
	input  logic                                 scale_wr_en,
	input  logic [oas_pkg::SCALE_W-1:0]          scale_wr_data,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [oas_pkg::CHAN_OUT_W-1:0]       channel,
	output logic [oas_pkg::SAMPLE_W-1:0]         average,
	output logic [oas_pkg::SCALE_W-1:0]          scaled_value
);
	import oas_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH = CHANNELS * RING_LEN;
	localparam int AW    = $clog2(DEPTH);

	logic [CH_W-1:0]     ch_q;
	logic [POS_W-1:0]    fill_q    [CHANNELS];
	logic [SAMPLE_W-1:0] raw_run_q [CHANNELS];
	logic [SAMPLE_W-1:0] avg_run_q [CHANNELS];
	logic [SCALE_W-1:0]  scale_q;
	logic [SAMPLE_W-1:0] sample_q;

	logic [IDX_W-1:0]    idx_q;
	logic                rd_vld_s1;
	logic [SUM_W-1:0]    total_q;
	logic [SAMPLE_W-1:0] lo_q, hi_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [PROD_W-1:0]   prod_q;

	logic [POS_W-1:0]    pos_cur;
	logic                pos_last;
	logic [SAMPLE_W:0]   raw_sum;
	logic [SAMPLE_W-1:0] raw_new;
	logic [AW-1:0]       base;
	logic                rd_en;
	logic [SAMPLE_W-1:0] rdata;
	logic [SUM_W-1:0]    trimmed;
	logic [SUM_W-1:0]    part;
	logic [SUM_W:0]      avg_sum;
	logic [SUM_W-1:0]    avg_half;
	logic [SAMPLE_W-1:0] avg_new;
	logic [CH_W+CHAN_OUT_W-1:0] ch_ext;

	assign pos_cur  = (fill_q[ch_q] >= POS_W'(RING_LEN)) ? '0 : fill_q[ch_q];
	assign pos_last = (pos_cur == POS_W'(RING_LEN - 1));
	assign raw_sum  = {1'b0, raw_run_q[ch_q]} + {1'b0, sample_q};
	assign raw_new  = raw_sum[SAMPLE_W:1];
	assign base     = AW'(ch_q) * AW'(RING_LEN);
	assign rd_en    = cmd.scan && (idx_q < IDX_W'(RING_LEN));

	oas_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (cmd.write_hist),
		.waddr(base + AW'(pos_cur)),
		.wdata(raw_new),
		.re   (rd_en),
		.raddr(base + AW'(idx_q)),
		.rdata(rdata)
	);

	// trimmed mean and smoothing
	assign trimmed  = total_q - SUM_W'(lo_q) - SUM_W'(hi_q);
	assign part     = trimmed >> AVG_SHIFT;
	assign avg_sum  = {1'b0, part} + (SUM_W + 1)'(avg_run_q[ch_q]);
	assign avg_half = avg_sum[SUM_W:1];
	assign avg_new  = (avg_half > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : avg_half[SAMPLE_W-1:0];

	assign ch_ext = {{CHAN_OUT_W{1'b0}}, ch_q};

	assign sts.wrap      = pos_last;
	assign sts.scan_done = (idx_q == IDX_W'(RING_LEN));
	assign sts.out_free  = !result_valid || !result_stall;

	// control and per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q         <= '0;
			scale_q      <= SCALE_RESET;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			result_valid <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				fill_q[i]    <= '0;
				raw_run_q[i] <= '0;
				avg_run_q[i] <= '0;
			end
		end else begin
			if (scale_wr_en) begin
				scale_q <= scale_wr_data;
			end
			if (cmd.write_hist) begin
				raw_run_q[ch_q] <= raw_new;
				fill_q[ch_q]    <= pos_last ? '0 : pos_cur + POS_W'(1);
				idx_q           <= '0;
				rd_vld_s1       <= 1'b0;
			end
			if (cmd.scan) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (cmd.calc_avg) begin
				avg_run_q[ch_q] <= avg_new;
			end
			if (cmd.advance) begin
				ch_q <= (ch_q == CH_W'(CHANNELS - 1)) ? '0 : ch_q + CH_W'(1);
			end
			if (cmd.emit) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= raw_sample;
		end
		if (cmd.write_hist) begin
			total_q <= '0;
			lo_q    <= SAMPLE_MAX;
			hi_q    <= '0;
		end else if (cmd.scan && rd_vld_s1) begin
			total_q <= total_q + SUM_W'(rdata);
			if (rdata < lo_q) begin
				lo_q <= rdata;
			end
			if (rdata > hi_q) begin
				hi_q <= rdata;
			end
		end
		if (cmd.calc_avg) begin
			avg_q <= avg_new;
		end
		if (cmd.calc_mul) begin
			prod_q <= PROD_W'(avg_q) * PROD_W'(scale_q);
		end
		if (cmd.emit) begin
			channel      <= ch_ext[CHAN_OUT_W-1:0];
			average      <= avg_q;
			scaled_value <= SCALE_W'(prod_q >> FRAC_W);
		end
	end

endmodule

// ===== design/olympic_average_adc_smoother.sv =====
// Top level of the olympic average ADC smoother.
// Depends on oas_pkg, oas_ctrl, oas_dp (and through it oas_ram).

// Olympic-average ADC smoother. Each accepted request carries one 12-bit
// sample for the channel under an internal round-robin pointer (starting at
// channel 0 after reset, stepping once per request, wrapping at CHANNELS).
// The channel's raw running value becomes (raw + sample) / 2 and is written
// into that channel's 10-entry history ring. Every tenth request on a
// channel completes the ring: the ten entries are summed, the largest and
// smallest are dropped, the rest is shifted right by AVG_SHIFT and averaged
// with the previous smoothed value (saturating at 4095). Only then is a
// result produced: channel (pointer, low 3 bits), average, and
// scaled_value = (average * scale_factor) >> 16, millivolts at the reset
// scale of 52800. Other requests produce no result.
// Timing: a request that does not complete a ring goes through accept and
// history write; one that completes it then scans the history ring through
// the RAM's single read port, and goes on to smoothing, multiply and
// output load. sample_stall is high while a
// request is being worked on. A finished result sits in the output
// register while the next request is taken; the block waits only if a
// second result is ready while the first is still stalled.
// The history RAM holds CHANNELS*10 entries and needs no clearing pass:
// every entry is written before it is ever read.
// scale_factor is written through scale_wr_en / scale_wr_data; the user
// must write it only while the block is idle (the block does not enforce it).
module olympic_average_adc_smoother #(
	parameter int CHANNELS  = 8,
	parameter int AVG_SHIFT = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               scale_wr_en,
	input  logic [oas_pkg::SCALE_W-1:0]        scale_wr_data,
	// sample request
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [oas_pkg::SAMPLE_W-1:0]       raw_sample,
	// result request
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [oas_pkg::CHAN_OUT_W-1:0]     channel,
	output logic [oas_pkg::SAMPLE_W-1:0]       average,
	output logic [oas_pkg::SCALE_W-1:0]        scaled_value
);
	import oas_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	oas_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	oas_dp #(
		.CHANNELS (CHANNELS),
		.AVG_SHIFT(AVG_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.raw_sample   (raw_sample),
		.scale_wr_en  (scale_wr_en),
		.scale_wr_data(scale_wr_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.channel      (channel),
		.average      (average),
		.scaled_value (scaled_value)
	);

`ifndef NO_ASSERTIONS
	// one request at a time: the cycle after an accept is always stalled
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("request accepted while previous one in progress");

	// a new result never overwrites one still held by a stalled consumer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && result_valid && result_stall))
		else $error("output register overwritten while stalled");

	// a result only appears from the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.emit))
		else $error("result appeared without emit");
`endif

endmodule

// ===== dv/oas_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the olympic average ADC smoother: watches both request channels
// and the scale write port, predicts each result and compares. Depends on oas_pkg.
module oas_checker #(
	parameter int CHANNELS  = 8,
	parameter int AVG_SHIFT = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               scale_wr_en,
	input  logic [oas_pkg::SCALE_W-1:0]        scale_wr_data,
	input  logic                               sample_valid,
	input  logic                               sample_stall,
	input  logic [oas_pkg::SAMPLE_W-1:0]       raw_sample,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic [oas_pkg::CHAN_OUT_W-1:0]     channel,
	input  logic [oas_pkg::SAMPLE_W-1:0]       average,
	input  logic [oas_pkg::SCALE_W-1:0]        scaled_value,
	output int                                 mismatches,
	output int                                 pending
);

	typedef struct packed {
		logic [oas_pkg::CHAN_OUT_W-1:0] chan;
		logic [oas_pkg::SAMPLE_W-1:0]   avg;
		logic [oas_pkg::SCALE_W-1:0]    scaled;
	} smoothed_t;

	smoothed_t smoothed_q[$];

	logic [oas_pkg::SCALE_W-1:0]  scale;
	int                           chan_ptr;
	logic [oas_pkg::POS_W-1:0]    fill_pos [CHANNELS];
	logic [oas_pkg::SAMPLE_W-1:0] raw_run  [CHANNELS];
	logic [oas_pkg::SAMPLE_W-1:0] avg_run  [CHANNELS];
	logic [oas_pkg::SAMPLE_W-1:0] hist     [CHANNELS][oas_pkg::RING_LEN];

	int err_cnt  = 0;
	int pend_cnt = 0;

	assign mismatches = err_cnt;
	assign pending    = pend_cnt;

	always @(posedge clk or negedge arst_n) begin : smooth_model
		int          ch, k;
		int unsigned total, lo, hi, avg_new;
		smoothed_t   exp_res, got_res;
		if (!arst_n) begin
			scale    = oas_pkg::SCALE_RESET;
			chan_ptr = 0;
			for (k = 0; k < CHANNELS; k++) begin
				fill_pos[k] = '0;
				raw_run[k]  = '0;
				avg_run[k]  = '0;
			end
			smoothed_q.delete();
			pend_cnt = 0;
		end else begin
			// results first: one accepted now always belongs to an older request
			if (result_valid && !result_stall) begin
				got_res = '{chan: channel, avg: average, scaled: scaled_value};
				if (smoothed_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: unexpected result ch %0d avg %0d scaled %0d",
							$realtime, channel, average, scaled_value);
				end else begin
					exp_res = smoothed_q.pop_front();
					if (got_res.chan !== exp_res.chan || got_res.avg !== exp_res.avg ||
					    got_res.scaled !== exp_res.scaled) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: mismatch ch %0d avg %0d scaled %0d, expected ch %0d avg %0d scaled %0d",
								$realtime, channel, average, scaled_value,
								exp_res.chan, exp_res.avg, exp_res.scaled);
					end
				end
			end

			if (scale_wr_en)
				scale = scale_wr_data;

			if (sample_valid && !sample_stall) begin
				ch = chan_ptr;
				raw_run[ch] = oas_pkg::SAMPLE_W'((int'(raw_run[ch]) + int'(raw_sample)) >> 1);
				hist[ch][fill_pos[ch]] = raw_run[ch];
				if (fill_pos[ch] == oas_pkg::RING_LEN - 1) begin
					// ring full: trimmed sum, then blend with previous average
					fill_pos[ch] = '0;
					total = 0;
					lo    = oas_pkg::SAMPLE_MAX;
					hi    = 0;
					for (k = 0; k < oas_pkg::RING_LEN; k++) begin
						total += hist[ch][k];
						if (hist[ch][k] < lo) lo = hist[ch][k];
						if (hist[ch][k] > hi) hi = hist[ch][k];
					end
					total   = total - lo - hi;
					avg_new = (int'(avg_run[ch]) + (total >> AVG_SHIFT)) >> 1;
					if (avg_new > oas_pkg::SAMPLE_MAX)
						avg_new = oas_pkg::SAMPLE_MAX;
					avg_run[ch] = oas_pkg::SAMPLE_W'(avg_new);
					exp_res.chan   = oas_pkg::CHAN_OUT_W'(ch);
					exp_res.avg    = oas_pkg::SAMPLE_W'(avg_new);
					exp_res.scaled = oas_pkg::SCALE_W'((avg_new * int'(scale)) >> oas_pkg::FRAC_W);
					smoothed_q.push_back(exp_res);
				end else begin
					fill_pos[ch] = fill_pos[ch] + 1'b1;
				end
				chan_ptr = (ch + 1 >= CHANNELS) ? 0 : ch + 1;
			end
			pend_cnt = smoothed_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the olympic average ADC smoother testbench: clock, reset, sample
// stimulus, scale writes and verdict. Depends on oas_pkg, the block and oas_checker.
module tb_top;

	localparam int CHANNELS    = 8;
	localparam int AVG_SHIFT   = 3;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 268;
	// settle time after the last expected result: covers a ring-completing
	// request, the longest kind, that is still in flight
	localparam int SETTLE      = 24;
	localparam int LIMIT_CYC   = 1_000_000;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           scale_wr_en   = 1'b0;
	logic [oas_pkg::SCALE_W-1:0]    scale_wr_data = '0;
	logic                           sample_valid  = 1'b0;
	logic                           sample_stall;
	logic [oas_pkg::SAMPLE_W-1:0]   raw_sample    = '0;
	logic                           result_valid;
	logic                           result_stall  = 1'b0;
	logic [oas_pkg::CHAN_OUT_W-1:0] channel;
	logic [oas_pkg::SAMPLE_W-1:0]   average;
	logic [oas_pkg::SCALE_W-1:0]    scaled_value;

	int mismatches;
	int pending;

	// idle knobs, changed per phase so some phases run back to back
	bit gaps_on   = 1'b0;
	bit stalls_on = 1'b0;
	int stall_left = 0;

	// level that the "steady signal" style wanders around
	int level = 2048;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	olympic_average_adc_smoother #(
		.CHANNELS  (CHANNELS),
		.AVG_SHIFT (AVG_SHIFT)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.scale_wr_en   (scale_wr_en),
		.scale_wr_data (scale_wr_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.raw_sample    (raw_sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.channel       (channel),
		.average       (average),
		.scaled_value  (scaled_value)
	);

	oas_checker #(
		.CHANNELS  (CHANNELS),
		.AVG_SHIFT (AVG_SHIFT)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.scale_wr_en   (scale_wr_en),
		.scale_wr_data (scale_wr_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.raw_sample    (raw_sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.channel       (channel),
		.average       (average),
		.scaled_value  (scaled_value),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// sample shapes: uniform, corner values, or a noisy steady level;
	// a fifth of the time plain uniform noise regardless of style
	function automatic logic [oas_pkg::SAMPLE_W-1:0] next_sample(input int style);
		int v;
		if ($urandom_range(0, 4) == 0 || style == 0)
			return oas_pkg::SAMPLE_W'($urandom);
		if (style == 1) begin
			case ($urandom_range(0, 5))
				0, 1: v = 0;
				2, 3: v = oas_pkg::SAMPLE_MAX;
				4:    v = $urandom_range(0, 3);
				default: v = $urandom_range(4092, 4095);
			endcase
			return oas_pkg::SAMPLE_W'(v);
		end
		if ($urandom_range(0, 31) == 0)
			level = $urandom_range(0, 4095);
		v = level + $urandom_range(0, 64) - 32;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return oas_pkg::SAMPLE_W'(v);
	endfunction

	// result side back-pressure: a stall burst of random length now and then
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 2) == 0) begin
			stall_left   <= idle_len();
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// one sample request; returns at the edge where it was taken.
	// valid stays high into the next request when there is no gap
	task automatic send_sample(input logic [oas_pkg::SAMPLE_W-1:0] s);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			raw_sample   <= oas_pkg::SAMPLE_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		raw_sample   <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	// drop valid, let the checker see the last request, then drain
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [oas_pkg::SAMPLE_W-1:0] corner_seq [24];
		logic [oas_pkg::SCALE_W-1:0]  scale_set  [PHASES];
		int p, n;
		corner_seq = '{12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h001, 12'hFFE,
		               12'h800, 12'h7FF, 12'hAAA, 12'h555, 12'hFFF, 12'hFFF,
		               12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000,
		               12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000};
		// extremes first, reset value again, then midpoint and random
		scale_set = '{16'hFFFF, 16'h0000, 16'h0001, oas_pkg::SCALE_RESET, 16'h8000,
		              16'h0000, 16'h0000};
		scale_set[5] = oas_pkg::SCALE_W'($urandom);
		scale_set[6] = oas_pkg::SCALE_W'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner samples at the reset scale, no idling
		for (n = 0; n < 24; n++)
			send_sample(corner_seq[n]);
		drain();

		for (p = 0; p < PHASES; p++) begin
			// scale only changes while the block is idle
			scale_wr_en   <= 1'b1;
			scale_wr_data <= scale_set[p];
			@(posedge clk);
			scale_wr_en   <= 1'b0;

			gaps_on   = (p % 3) != 1;
			stalls_on = (p % 3) != 2;
			for (n = 0; n < PHASE_ITEMS; n++)
				send_sample(next_sample(p % 3));
			drain();
		end

		// one more settle with all idling off so a stray result would show
		stalls_on = 1'b0;
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_CYC * 8);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/oas_pkg.sv
design/oas_ram.sv
design/oas_ctrl.sv
design/oas_dp.sv
design/olympic_average_adc_smoother.sv
dv/oas_checker.sv
dv/tb_top.sv
